### hdl/hrlg_pkg.sv
// ----------------------------------------------------------------------------
// hrlg_pkg
// Shared types, codes and character constants for the request length guard.
// ----------------------------------------------------------------------------
package hrlg_pkg;

	// largest request the buffer can ever hold
	localparam int unsigned MAX_REQUEST_BYTES = 65536;
	localparam int unsigned CAP_LIMIT_INT     =
		(MAX_REQUEST_BYTES < 65536) ? MAX_REQUEST_BYTES : 65536;

	localparam int CNT_W   = 17;
	localparam int SEC_W   = 8;
	localparam int IDX_W   = 1;

	localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(CAP_LIMIT_INT);
	localparam logic [CNT_W-1:0] CAP_FLOOR = CNT_W'(2);
	localparam logic [CNT_W-1:0] LEN_SAT   = 17'h1FFFF;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_MAX_BYTES = 1'd0;
	localparam logic [IDX_W-1:0] REG_DEADLINE  = 1'd1;

	localparam logic [CNT_W-1:0] MAX_BYTES_RST = 17'd8192;
	localparam logic [SEC_W-1:0] DEADLINE_RST  = 8'd10;

	// event codes
	localparam logic [1:0] FUNC_DATA  = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_CLOSE = 2'd2;
	localparam logic [1:0] FUNC_START = 2'd3;

	// result status codes
	localparam logic [2:0] ST_COMPLETE  = 3'd0;
	localparam logic [2:0] ST_CLOSED    = 3'd1;
	localparam logic [2:0] ST_TIMEOUT   = 3'd2;
	localparam logic [2:0] ST_OVERSIZE  = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE = 3'd4;

	// header scan phases
	localparam logic [2:0] PH_WAIT  = 3'd0;
	localparam logic [2:0] PH_NAME  = 3'd1;
	localparam logic [2:0] PH_BLANK = 3'd2;
	localparam logic [2:0] PH_DIGIT = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;

	localparam logic [3:0] NAME_LEN = 4'd14;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// header scanner state seen by the top level
	typedef struct packed {
		logic             headers_finished;
		logic [CNT_W-1:0] declared_length;
	} scan_state_t;

	// lower-case header name, one character per position
	function automatic logic [7:0] hdr_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h63; // c
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h6C; // l
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// blank line pattern cr lf cr lf
	function automatic logic [7:0] blank_char(input logic [1:0] idx);
		return idx[0] ? CH_LF : CH_CR;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? (b + 8'd32) : b;
	endfunction

endpackage

### hdl/http_request_length_guard_unit.sv
// ----------------------------------------------------------------------------
// http_request_length_guard_unit
// Framing guard for one HTTP request fed as a stream of byte and tick events.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one event (func, data_byte) per
// transaction: data byte, one-second tick, peer closed or start of request.
// Output channel: out_valid / out_stall carry a status and the byte count of
// the request whenever an event ends it; most events give no result.
// Configuration: cfg_valid / cfg_ready write max_bytes (index 0) or
// deadline_seconds (index 1); cfg_ready is always high. Write only while idle.
// Pipeline: an event is taken into an input register and evaluated against the
// request state there; its result is written into the output register, which
// drives out_valid, when the evaluation stage advances.
// Throughput: one event per cycle while no result is stalled, set by the single
// evaluation stage. When out_stall holds a waiting result, the evaluation stage
// holds its event and in_stall rises once the input register is occupied.
// Reset (arst_n low) clears the request state, restores max_bytes to 8192 and
// deadline_seconds to 10, and leaves the block idle until a start event.
// ----------------------------------------------------------------------------
module http_request_length_guard_unit import hrlg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic [7:0]        data_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [15:0]       byte_count,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CNT_W-1:0]  cfg_data
);

	logic [CNT_W-1:0] max_bytes_q;
	logic [SEC_W-1:0] deadline_q;

	logic             valid_s1;
	logic [1:0]       func_s1;
	logic [7:0]       byte_s1;

	logic             active_q;
	logic [CNT_W-1:0] total_q;
	logic [SEC_W-1:0] elapsed_q;
	logic [CNT_W-1:0] body_q;

	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [15:0]      count_q;

	logic             can_go, adv;
	logic [CNT_W-1:0] cap, cap_m1;
	logic [SEC_W-1:0] elapsed_inc;
	logic [CNT_W-1:0] total_inc, body_inc;
	logic             data_late;
	logic             scan_clear, scan_en;
	scan_state_t      scan_cur, scan_nxt;

	logic             res_fire;
	logic [2:0]       res_status;
	logic [15:0]      res_count;
	logic             active_n;
	logic [CNT_W-1:0] total_n, body_n;
	logic [SEC_W-1:0] elapsed_n;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RST;
			deadline_q  <= DEADLINE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MAX_BYTES)
				max_bytes_q <= cfg_data;
			else if (cfg_index == REG_DEADLINE)
				deadline_q <= cfg_data[SEC_W-1:0];
		end
	end

	// effective capacity
	always_comb begin
		cap = max_bytes_q;
		if (cap > CAP_LIMIT)
			cap = CAP_LIMIT;
		if (cap < CAP_FLOOR)
			cap = CAP_FLOOR;
	end
	assign cap_m1 = cap - CNT_W'(1);

	// input register and flow control
	assign can_go   = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && can_go;
	assign in_stall = valid_s1 && !can_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			func_s1 <= func;
			byte_s1 <= data_byte;
		end
	end

	// header scanner
	assign elapsed_inc = (elapsed_q == {SEC_W{1'b1}}) ? elapsed_q : elapsed_q + SEC_W'(1);
	assign data_late   = (elapsed_q >= deadline_q);
	assign total_inc   = total_q + CNT_W'(1);
	assign body_inc    = body_q + CNT_W'(1);
	assign scan_clear  = adv && (func_s1 == FUNC_START);
	assign scan_en     = adv && active_q && (func_s1 == FUNC_DATA) && !data_late &&
		!scan_cur.headers_finished;

	hrlg_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (scan_clear),
		.byte_en   (scan_en),
		.data_byte (byte_s1),
		.cur       (scan_cur),
		.nxt       (scan_nxt)
	);

	// event evaluation
	always_comb begin
		res_fire   = 1'b0;
		res_status = ST_COMPLETE;
		res_count  = total_q[15:0];
		active_n   = active_q;
		total_n    = total_q;
		body_n     = body_q;
		elapsed_n  = elapsed_q;
		if (func_s1 == FUNC_START) begin
			active_n  = 1'b1;
			total_n   = '0;
			body_n    = '0;
			elapsed_n = '0;
		end else if (active_q) begin
			unique case (func_s1)
				FUNC_CLOSE: begin
					res_fire   = 1'b1;
					res_status = ST_CLOSED;
				end
				FUNC_TICK: begin
					elapsed_n = elapsed_inc;
					if (elapsed_inc >= deadline_q) begin
						res_fire   = 1'b1;
						res_status = ST_TIMEOUT;
					end
				end
				default: begin
					if (data_late) begin
						res_fire   = 1'b1;
						res_status = ST_TIMEOUT;
					end else begin
						total_n   = total_inc;
						res_count = total_inc[15:0];
						if (scan_cur.headers_finished)
							body_n = body_inc;
						priority if (!scan_cur.headers_finished &&
							scan_nxt.headers_finished &&
							scan_nxt.declared_length > cap) begin
							res_fire   = 1'b1;
							res_status = ST_TOO_LARGE;
						end else if (scan_nxt.headers_finished &&
							body_n >= scan_nxt.declared_length) begin
							res_fire   = 1'b1;
							res_status = ST_COMPLETE;
						end else if (total_inc >= cap_m1) begin
							res_fire   = 1'b1;
							res_status = ST_OVERSIZE;
						end else begin
							res_fire = 1'b0;
						end
					end
				end
			endcase
			if (res_fire)
				active_n = 1'b0;
		end
	end

	// request state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			total_q   <= '0;
			body_q    <= '0;
			elapsed_q <= '0;
		end else if (adv) begin
			active_q  <= active_n;
			total_q   <= total_n;
			body_q    <= body_n;
			elapsed_q <= elapsed_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && res_fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && res_fire) begin
			status_q <= res_status;
			count_q  <= res_count;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign byte_count = count_q;

	// checks
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_result_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !(adv && res_fire)) |=> !out_valid_q)
		else $error("taken result not cleared");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (total_q[CNT_W-1] == 1'b0 && body_q <= total_q))
		else $error("byte counters out of range");

	a_result_ends_request: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_fire) |=> !active_q)
		else $error("request still active after result");

endmodule

### hdl/hrlg_scan.sv
// ----------------------------------------------------------------------------
// hrlg_scan
// Header scanner: finds the blank line ending the headers and parses the first
// Content-Length header value. Presents next-state values for the same cycle.
// ----------------------------------------------------------------------------
module hrlg_scan import hrlg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic        byte_en,
	input  logic [7:0]  data_byte,
	output scan_state_t cur,
	output scan_state_t nxt
);

	logic [2:0]       phase_q, phase_n;
	logic [3:0]       pos_q, pos_n;
	logic             line_start_q, line_start_n;
	logic [1:0]       end_prog_q, end_prog_n;
	logic             hf_q, hf_n;
	logic [CNT_W-1:0] dl_q, dl_n;

	logic [7:0]  low_c;
	logic        is_digit;
	logic [3:0]  digit;
	logic [20:0] dl_x10;

	assign low_c    = to_lower(data_byte);
	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign digit    = data_byte[3:0];
	assign dl_x10   = ({4'd0, dl_q} << 3) + ({4'd0, dl_q} << 1) + {17'd0, digit};

	// next state for one header byte
	always_comb begin
		phase_n      = phase_q;
		pos_n        = pos_q;
		line_start_n = line_start_q;
		end_prog_n   = end_prog_q;
		hf_n         = hf_q;
		dl_n         = dl_q;
		if (byte_en) begin
			line_start_n = (data_byte == CH_LF);
			unique case (phase_q)
				PH_WAIT: begin
					if (line_start_q && low_c == hdr_char(4'd0)) begin
						phase_n = PH_NAME;
						pos_n   = 4'd1;
					end
				end
				PH_NAME: begin
					if (pos_q < NAME_LEN) begin
						if (low_c == hdr_char(pos_q))
							pos_n = pos_q + 4'd1;
						else
							phase_n = PH_WAIT;
					end else begin
						phase_n = (data_byte == CH_COLON) ? PH_BLANK : PH_WAIT;
					end
				end
				PH_BLANK: begin
					if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
						phase_n = PH_BLANK;
					end else if (is_digit) begin
						phase_n = PH_DIGIT;
						dl_n    = {13'd0, digit};
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_DIGIT: begin
					if (is_digit)
						dl_n = (dl_x10 > {4'd0, LEN_SAT}) ? LEN_SAT : dl_x10[CNT_W-1:0];
					else
						phase_n = PH_DONE;
				end
				default: begin
					phase_n = phase_q;
				end
			endcase

			// blank line detection
			if (data_byte == blank_char(end_prog_q)) begin
				if (end_prog_q == 2'd3) begin
					hf_n       = 1'b1;
					end_prog_n = 2'd0;
				end else begin
					end_prog_n = end_prog_q + 2'd1;
				end
			end else begin
				end_prog_n = (data_byte == CH_CR) ? 2'd1 : 2'd0;
			end
		end
	end

	// scanner registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			pos_q        <= '0;
			line_start_q <= 1'b0;
			end_prog_q   <= '0;
			hf_q         <= 1'b0;
			dl_q         <= '0;
		end else if (clear) begin
			phase_q      <= PH_WAIT;
			pos_q        <= '0;
			line_start_q <= 1'b0;
			end_prog_q   <= '0;
			hf_q         <= 1'b0;
			dl_q         <= '0;
		end else begin
			phase_q      <= phase_n;
			pos_q        <= pos_n;
			line_start_q <= line_start_n;
			end_prog_q   <= end_prog_n;
			hf_q         <= hf_n;
			dl_q         <= dl_n;
		end
	end

	assign cur.headers_finished = hf_q;
	assign cur.declared_length  = dl_q;
	assign nxt.headers_finished = hf_n;
	assign nxt.declared_length  = dl_n;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP request length guard.
// A short table of directed events runs at the reset configuration. Several
// configuration phases with random requests follow. The requests are mostly
// well-formed, with random header case, blanks, digit strings, junk lines and
// early closes. Every accepted transaction goes through a local model of the
// guard, and each result is checked against the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module tb;
	import hrlg_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 70;

	// one expected result
	typedef struct packed {
		logic [2:0]  code;
		logic [15:0] nbytes;
	} verdict_t;

	// one directed row; a pinned row carries its own verdict
	typedef struct packed {
		logic [1:0] f;
		logic [7:0] b;
		logic       pinned;
		verdict_t   v;
	} row_t;

	localparam verdict_t NO_VERDICT = '0;
	localparam logic [111:0] HDR_NAME = "content-length";

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        func;
	logic [7:0]        data_byte;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        status;
	logic [15:0]       byte_count;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [CNT_W-1:0]  cfg_data;

	// model state of the guard
	logic [16:0] cap_cfg       = MAX_BYTES_RST;
	logic [7:0]  deadline_cfg  = DEADLINE_RST;
	logic        req_open      = 1'b0;
	logic [16:0] byte_total    = '0;
	logic [7:0]  secs          = '0;
	logic [1:0]  crlf_seen     = '0;
	logic        hdr_done      = 1'b0;
	logic [16:0] body_total    = '0;
	logic [2:0]  hunt_phase    = PH_WAIT;
	logic [3:0]  name_idx      = '0;
	logic        at_line_start = 1'b0;
	logic [16:0] clen          = '0;

	verdict_t pending_verdicts [$];
	row_t     dir_tab [$];
	bit       pin_valid;
	verdict_t pin_verdict;
	bit       calm;
	bit       long_hold;
	int       err_count;
	int       items_sent;
	int       results_due;
	int       cycle_count;

	http_request_length_guard_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.byte_count (byte_count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// capacity after clamping
	function automatic logic [16:0] eff_cap();
		logic [16:0] c;
		c = cap_cfg;
		if (c > CAP_LIMIT) c = CAP_LIMIT;
		if (c < CAP_FLOOR) c = CAP_FLOOR;
		return c;
	endfunction

	function automatic logic [7:0] name_at(input int idx);
		return HDR_NAME[8*(13-idx) +: 8];
	endfunction

	// advance the guard model by one event, return 1 when it ends the request
	function automatic bit predict_guard(input logic [1:0] f, input logic [7:0] b,
			output verdict_t v);
		logic [16:0] cap;
		logic [7:0]  lc;
		logic        was_start;
		logic [31:0] acc;
		bit          done;
		cap = eff_cap();
		v = NO_VERDICT;
		done = 1'b0;
		if (f == FUNC_START) begin
			req_open = 1'b1;
			byte_total = '0;
			secs = '0;
			crlf_seen = '0;
			hdr_done = 1'b0;
			body_total = '0;
			hunt_phase = PH_WAIT;
			name_idx = '0;
			at_line_start = 1'b0;
			clen = '0;
			return 1'b0;
		end
		if (!req_open) return 1'b0;
		if (f == FUNC_CLOSE) begin
			v.code = ST_CLOSED;
			done = 1'b1;
		end else if (f == FUNC_TICK) begin
			if (secs != 8'hFF) secs = secs + 8'd1;
			if (secs >= deadline_cfg) begin
				v.code = ST_TIMEOUT;
				done = 1'b1;
			end
		end else if (secs >= deadline_cfg) begin
			// the late byte is not counted
			v.code = ST_TIMEOUT;
			done = 1'b1;
		end else begin
			byte_total = byte_total + 17'd1;
			if (hdr_done) begin
				body_total = body_total + 17'd1;
			end else begin
				// header name, blanks and digits
				was_start = at_line_start;
				at_line_start = (b == CH_LF);
				lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
				case (hunt_phase)
					PH_WAIT: begin
						if (was_start && lc == name_at(0)) begin
							hunt_phase = PH_NAME;
							name_idx = 4'd1;
						end
					end
					PH_NAME: begin
						if (name_idx < NAME_LEN) begin
							if (lc == name_at(name_idx)) name_idx = name_idx + 4'd1;
							else hunt_phase = PH_WAIT;
						end else begin
							hunt_phase = (b == CH_COLON) ? PH_BLANK : PH_WAIT;
						end
					end
					PH_BLANK: begin
						if (b >= CH_ZERO && b <= CH_NINE) begin
							hunt_phase = PH_DIGIT;
							clen = 17'(b - CH_ZERO);
						end else if (b != CH_SPACE && b != CH_TAB) begin
							hunt_phase = PH_DONE;
						end
					end
					PH_DIGIT: begin
						if (b >= CH_ZERO && b <= CH_NINE) begin
							acc = 32'(clen) * 32'd10 + 32'(b - CH_ZERO);
							clen = (acc > 32'(LEN_SAT)) ? LEN_SAT : acc[16:0];
						end else begin
							hunt_phase = PH_DONE;
						end
					end
					default: begin
					end
				endcase
				// blank line that ends the headers
				if (b == (crlf_seen[0] ? CH_LF : CH_CR)) begin
					if (crlf_seen == 2'd3) begin
						hdr_done = 1'b1;
						crlf_seen = 2'd0;
					end else begin
						crlf_seen = crlf_seen + 2'd1;
					end
				end else begin
					crlf_seen = (b == CH_CR) ? 2'd1 : 2'd0;
				end
				if (hdr_done && clen > cap) begin
					v.code = ST_TOO_LARGE;
					done = 1'b1;
				end
			end
			if (!done) begin
				if (hdr_done && body_total >= clen) begin
					v.code = ST_COMPLETE;
					done = 1'b1;
				end else if (byte_total >= cap - 17'd1) begin
					v.code = ST_OVERSIZE;
					done = 1'b1;
				end
			end
		end
		if (done) begin
			v.nbytes = byte_total[15:0];
			req_open = 1'b0;
		end
		return done;
	endfunction

	task automatic log_error(input string what);
		err_count++;
		if (err_count <= 10) $display("error at %0t: %s", $time, what);
	endtask

	// offer one event and hold it until the transaction completes
	task automatic offer_event(input logic [1:0] f, input logic [7:0] b);
		verdict_t v;
		bit       got;
		bit       live;
		in_valid <= 1'b1;
		func <= f;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		live = req_open || (f == FUNC_START);
		got = predict_guard(f, b, v);
		if (pin_valid) begin
			v = pin_verdict;
			got = 1'b1;
			pin_valid = 1'b0;
		end
		if (got) begin
			pending_verdicts.push_back(v);
			results_due++;
		end
		if (live) items_sent++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// a request byte, now and then preceded by a tick
	task automatic put_byte(input logic [7:0] b);
		if (!req_open) return;
		if ($urandom_range(0, 29) == 0) offer_event(FUNC_TICK, 8'($urandom_range(0, 255)));
		if (req_open) offer_event(FUNC_DATA, b);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put_byte(s.getc(i));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_MAX_BYTES) cap_cfg = val;
		else deadline_cfg = val[7:0];
	endtask

	function automatic string mixed_case(input string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++) begin
			if (r.getc(i) >= 8'h61 && r.getc(i) <= 8'h7A && $urandom_range(0, 1))
				r.putc(i, r.getc(i) - 8'd32);
		end
		return r;
	endfunction

	// digit string of a content-length value
	function automatic string length_text();
		string s;
		case ($urandom_range(0, 7))
			0: s = "";
			1: s = $sformatf("%0d", eff_cap() + $urandom_range(1, 5));
			2: s = $sformatf("%0d%0d", $urandom_range(1, 999), $urandom_range(1000000, 9999999));
			3: s = $sformatf("00%0d", $urandom_range(0, 9));
			default: s = $sformatf("%0d", $urandom_range(0, 24));
		endcase
		return s;
	endfunction

	// one request: start line, headers, blank line, body, sometimes cut short
	task automatic run_request();
		string line;
		int    stop_at;
		int    n;
		offer_event(FUNC_START, 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 5) != 0) begin
			repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(33, 126)));
			put_text("\r\n");
		end
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					put_text(mixed_case("content-length"));
					put_text(":");
					repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
					put_text(length_text());
					if ($urandom_range(0, 5) == 0) put_text(" ;q");
				end
				4, 5: begin
					// near miss: bad name character or no colon
					line = mixed_case("content-length");
					if ($urandom_range(0, 1)) begin
						line.putc($urandom_range(0, 13), 8'(8'h61 + $urandom_range(0, 25)));
						put_text(line);
						put_text(": 7");
					end else begin
						put_text(line);
						put_text($urandom_range(0, 1) ? " 3" : "x: 3");
					end
				end
				6, 7, 8: begin
					put_text("X-");
					repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(8'h61, 8'h7A)));
					put_text(": ");
					repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(33, 126)));
				end
				default: begin
					repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
				end
			endcase
			put_text("\r\n");
		end
		put_text("\r\n");
		stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 64;
		n = 0;
		while (req_open && n < stop_at) begin
			put_byte(8'($urandom_range(0, 255)));
			n++;
		end
		if (req_open) begin
			case ($urandom_range(0, 2))
				0: offer_event(FUNC_CLOSE, 8'($urandom_range(0, 255)));
				1: begin
					while (req_open && deadline_cfg <= 20)
						offer_event(FUNC_TICK, 8'($urandom_range(0, 255)));
				end
				default: begin
				end
			endcase
		end
	endtask

	// result side: random stalls and one long hold-off on request
	initial begin : out_side
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (80) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 7);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result transaction with the oldest verdict
	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				log_error($sformatf("unexpected result status %0d count %0d", status, byte_count));
			end else begin
				want = pending_verdicts.pop_front();
				if (status !== want.code)
					log_error($sformatf("status expected %0d actual %0d", want.code, status));
				if (byte_count !== want.nbytes)
					log_error($sformatf("byte_count expected %0d actual %0d", want.nbytes,
						byte_count));
			end
		end
	end

	// stimulus
	initial begin : stim
		row_t        r;
		logic [16:0] mb;
		logic [7:0]  dl;
		int          base;
		in_valid = 1'b0;
		func = FUNC_DATA;
		data_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_BYTES;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset configuration
		dir_tab.push_back({FUNC_DATA,  8'h41, 1'b0, NO_VERDICT}); // idle block ignores events
		dir_tab.push_back({FUNC_TICK,  8'hFF, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_CLOSE, 8'h00, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_START, 8'h00, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_CLOSE, 8'h00, 1'b1, ST_CLOSED, 16'd0});
		dir_tab.push_back({FUNC_START, 8'hFF, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_DATA,  CH_CR, 1'b0, NO_VERDICT}); // bare blank line
		dir_tab.push_back({FUNC_DATA,  CH_LF, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_DATA,  CH_CR, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_DATA,  CH_LF, 1'b1, ST_COMPLETE, 16'd4});
		dir_tab.push_back({FUNC_START, 8'h00, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_DATA,  8'hFF, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_DATA,  8'h00, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_START, 8'h55, 1'b0, NO_VERDICT}); // restart drops the request
		dir_tab.push_back({FUNC_DATA,  8'h00, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_CLOSE, 8'hAA, 1'b1, ST_CLOSED, 16'd1});
		dir_tab.push_back({FUNC_START, 8'h00, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_TICK,  8'h00, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_DATA,  CH_LF, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_DATA,  CH_CR, 1'b0, NO_VERDICT});
		dir_tab.push_back({FUNC_CLOSE, 8'h00, 1'b1, ST_CLOSED, 16'd2});
		foreach (dir_tab[i]) begin
			r = dir_tab[i];
			pin_valid = r.pinned;
			pin_verdict = r.v;
			offer_event(r.f, r.b);
		end
		drain_results();

		// configuration phases with random requests
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin mb = 17'd0;      dl = 8'd0;   end
				1: begin mb = 17'd2;      dl = 8'd1;   end
				2: begin mb = 17'd131071; dl = 8'd255; end
				3: begin mb = 17'd65536;  dl = 8'd3;   end
				4: begin mb = 17'd40;     dl = 8'd5;   end
				5: begin mb = 17'd1;      dl = 8'd255; end
				default: begin
					mb = 17'($urandom_range(2, 300));
					dl = 8'($urandom_range(2, 40));
				end
			endcase
			write_reg(REG_MAX_BYTES, mb);
			write_reg(REG_DEADLINE, {9'($urandom_range(0, 511)), dl});
			cfg_valid <= 1'b0;
			@(posedge clk);
			if (ph == PHASES - 1) calm = 1'b1;
			if (ph == 2) begin
				// hold the result side off while short requests keep coming
				calm = 1'b1;
				long_hold = 1'b1;
				repeat (24) begin
					offer_event(FUNC_START, 8'($urandom_range(0, 255)));
					offer_event(FUNC_CLOSE, 8'($urandom_range(0, 255)));
				end
				calm = 1'b0;
				drain_results();
			end
			base = items_sent;
			while (items_sent - base < PHASE_ITEMS || (ph == PHASES - 1 && results_due < 48)) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 6))
						offer_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				end else begin
					run_request();
				end
				if ($urandom_range(0, 7) == 0) drain_results();
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
